FILE: rtl/olafr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olafr_pkg: shared types and constants of the ordered list
// Field widths, op and status codes, item structs and the per-cycle cell
// control struct broadcast to the row of list cells.
// ----------------------------------------------------------------------------
package olafr_pkg;

	localparam int CAPACITY   = 16;
	localparam int ITEM_WIDTH = 32;

	localparam int OP_W     = 2;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd3;

	localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

	typedef logic [ITEM_WIDTH-1:0] entry_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   position;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    found_position;
		logic [COUNT_W-1:0]  item_count;
	} rsp_t;

	// broadcast to every cell in the cycle an item is accepted
	typedef struct packed {
		logic             append;
		logic             remove;
		entry_t           key;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] rm_from;
	} cell_ctl_t;

endpackage

FILE: rtl/olafr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olafr_cell: one list slot
// Holds one entry, compares it against the search key, passes the
// "earlier hit" flag down the row, loads the key on an append at its index,
// and on remove at or above the position takes its upper neighbor.
module olafr_cell (
	input  logic                       clk,
	input  olafr_pkg::cell_ctl_t       ctl,
	input  logic [olafr_pkg::IDX_W-1:0] idx,
	input  olafr_pkg::entry_t          next_entry,
	input  logic                       hit_in,
	output olafr_pkg::entry_t          entry,
	output logic                       hit_out,
	output logic                       first_hit
);
	import olafr_pkg::*;

	entry_t           entry_q;
	logic [CNT_W-1:0] my_idx;
	logic             live;
	logic             match;

	assign my_idx    = CNT_W'(idx);
	assign live      = my_idx < ctl.count;
	assign match     = live && (entry_q == ctl.key);
	assign first_hit = match && !hit_in;
	assign hit_out   = hit_in || match;
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.append && (my_idx == ctl.count)) begin
			entry_q <= ctl.key;
		end else if (ctl.remove && live && (my_idx >= ctl.rm_from)) begin
			entry_q <= next_entry;
		end
	end

endmodule

FILE: rtl/ordered_list_append_find_remove_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_append_find_remove_unit: ordered list with linear search
// Insertion-ordered list in a row of cells with append, find and remove.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one item per op: append
//   value, find value, or remove at position. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns exactly one item per request with
//   status, found_position and the item count after the op.
//   Latency: the response is valid the cycle after the request is taken.
//   Throughput: one item per cycle while rsp_ready is high; every cell
//   compares and shifts in the same cycle as the op is accepted.
//   A response waiting in the output register does not block the next
//   request when rsp_ready is high in that cycle; while rsp_ready is low
//   with a response pending, req_ready drops and the list holds.
//   Reset empties the list (count to zero); entry contents are not cleared,
//   since only slots below the count are ever compared.
//   Unused op code 3 changes nothing and answers ok.
// ----------------------------------------------------------------------------
module ordered_list_append_find_remove_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  olafr_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output olafr_pkg::rsp_t   rsp
);
	import olafr_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	cell_ctl_t        ctl;
	entry_t           entries [CAPACITY];
	logic [CAPACITY:0] hit_chain;
	logic [CAPACITY-1:0] first_vec;

	logic             fire;
	logic             is_append, is_find, is_remove;
	logic             full, bad_pos, found;
	logic [IDX_W-1:0] first_idx;
	logic [CNT_W-1:0] count_d;
	rsp_t             rsp_d;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign fire      = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign is_append = req.op == OP_APPEND;
	assign is_find   = req.op == OP_FIND;
	assign is_remove = req.op == OP_REMOVE;
	assign full      = count_q >= CAP_COUNT;
	assign bad_pos   = CMP_W'(req.position) >= CMP_W'(count_q);

	always_comb begin
		ctl.append  = fire && is_append && !full;
		ctl.remove  = fire && is_remove && !bad_pos;
		ctl.key     = ITEM_WIDTH'(req.value);
		ctl.count   = count_q;
		ctl.rm_from = CNT_W'(req.position);
	end

	assign hit_chain[0] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			olafr_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.idx        (IDX_W'(gi)),
				.next_entry ((gi == CAPACITY - 1) ? entries[gi] :
					entries[(gi + 1) % CAPACITY]),
				.hit_in     (hit_chain[gi]),
				.entry      (entries[gi]),
				.hit_out    (hit_chain[gi+1]),
				.first_hit  (first_vec[gi])
			);
		end
	endgenerate

	assign found = hit_chain[CAPACITY];

	// first_vec is one-hot at most, so an OR of the indexes picks the hit
	always_comb begin
		first_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_vec[i]) begin
				first_idx = first_idx | IDX_W'(i);
			end
		end
	end

	always_comb begin
		count_d                = count_q;
		rsp_d.status           = ST_OK;
		rsp_d.found_position   = '0;
		case (req.op)
			OP_APPEND: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_FIND: begin
				if (found) begin
					rsp_d.found_position = POS_W'(first_idx);
				end else begin
					rsp_d.status = ST_NOT_FOUND;
				end
			end
			OP_REMOVE: begin
				if (bad_pos) begin
					rsp_d.status = ST_BAD_POS;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
		rsp_d.item_count = COUNT_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_COUNT)
		else $error("item count above capacity");

	a_count_holds_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(count_q))
		else $error("item count changed without an accepted item");

	a_single_first_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_vec))
		else $error("more than one first match in the row");

	a_full_reported: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_append && full |=> rsp_valid && (rsp.status == ST_FULL)
			&& $stable(count_q))
		else $error("append to a full list not reported");

	a_find_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_find |=> $stable(count_q))
		else $error("find changed the item count");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the ordered list with append, find and remove
// A queue-fed driver offers list ops on the req channel. A shadow list
// predicts each response when its request is accepted. A monitor checks every
// response, field by field, against the oldest prediction. Runs through
// phases of sender idling, receiver stalling and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

	import olafr_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int SLOTS = 16;
	localparam int CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	ordered_list_append_find_remove_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// shadow copy of the list
	logic [31:0] shadow_entries [SLOTS];
	int          shadow_count;

	req_t pending_req[$];
	rsp_t expected_rsp[$];

	int  send_idle_pct = 0;
	int  stall_pct = 0;
	int  errors = 0;
	int  cycles = 0;

	// receiver hold-off, armed by toggling rsp_hold_go
	logic rsp_hold_go = 1'b0;
	logic hold_seen;
	int   rsp_hold_len = 0;
	int   hold_left;

	logic [31:0] value_pool [8];

	function automatic rsp_t list_apply(req_t r);
		rsp_t o;
		int i;
		o = '0;
		case (r.op)
			OP_APPEND: begin
				if (shadow_count >= SLOTS) begin
					o.status = ST_FULL;
				end else begin
					shadow_entries[shadow_count] = r.value;
					shadow_count++;
					o.status = ST_OK;
				end
			end
			OP_FIND: begin
				o.status = ST_NOT_FOUND;
				for (i = 0; i < shadow_count; i++) begin
					if (shadow_entries[i] == r.value) begin
						o.status = ST_OK;
						o.found_position = POS_W'(i);
						break;
					end
				end
			end
			OP_REMOVE: begin
				if (int'(r.position) >= shadow_count) begin
					o.status = ST_BAD_POS;
				end else begin
					for (i = int'(r.position); i + 1 < shadow_count; i++)
						shadow_entries[i] = shadow_entries[i + 1];
					shadow_count--;
					o.status = ST_OK;
				end
			end
			default: o.status = ST_OK;
		endcase
		o.item_count = COUNT_W'(shadow_count);
		return o;
	endfunction

	task automatic queue_op(logic [OP_W-1:0] op, logic [31:0] value, logic [3:0] pos);
		req_t r;
		r.op = op;
		r.value = value;
		r.position = pos;
		pending_req.push_back(r);
	endtask

	function automatic logic [31:0] pick_value();
		if ($urandom_range(3) == 0)
			return $urandom;
		return value_pool[$urandom_range(7)];
	endfunction

	// bursts of 20 ops that lean toward filling, draining or a mix
	task automatic queue_random(int n);
		int mode;
		int roll;
		int k;
		int append_pct;
		int find_pct;
		int remove_pct;
		mode = 0;
		append_pct = 0;
		find_pct = 0;
		remove_pct = 0;
		for (k = 0; k < n; k++) begin
			if (k % 20 == 0) begin
				mode = $urandom_range(2);
				case (mode)
					0: begin append_pct = 70; find_pct = 20; remove_pct = 8; end
					1: begin append_pct = 15; find_pct = 20; remove_pct = 63; end
					default: begin append_pct = 35; find_pct = 35; remove_pct = 27; end
				endcase
			end
			roll = $urandom_range(99);
			if (roll < append_pct)
				queue_op(OP_APPEND, pick_value(), 4'($urandom));
			else if (roll < append_pct + find_pct)
				queue_op(OP_FIND, pick_value(), 4'($urandom));
			else if (roll < append_pct + find_pct + remove_pct)
				queue_op(OP_REMOVE, $urandom, 4'($urandom_range(15)));
			else
				queue_op(OP_UNUSED, $urandom, 4'($urandom));
		end
	endtask

	task automatic drain_all();
		while (pending_req.size() != 0 || expected_rsp.size() != 0 || req_valid)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready)
				expected_rsp.push_back(list_apply(req));
			if (!req_valid || req_ready) begin
				if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= pending_req.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_seen <= 1'b0;
		end else if (rsp_hold_go != hold_seen) begin
			hold_seen <= rsp_hold_go;
			hold_left <= rsp_hold_len;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					$error("unexpected item: status %0d found_position %0d item_count %0d",
						rsp.status, rsp.found_position, rsp.item_count);
					errors++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						errors++;
					end
					if (rsp.found_position !== want.found_position) begin
						$error("found_position: expected %0d, got %0d",
							want.found_position, rsp.found_position);
						errors++;
					end
					if (rsp.item_count !== want.item_count) begin
						$error("item_count: expected %0d, got %0d",
							want.item_count, rsp.item_count);
						errors++;
					end
				end
			end
			rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[ordered_list_append_find_remove_unit] ERROR");
			$finish;
		end
	end

	initial begin
		int i;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		shadow_count = 0;
		for (i = 0; i < SLOTS; i++)
			shadow_entries[i] = '0;
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		for (i = 2; i < 8; i++)
			value_pool[i] = $urandom;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty list, extremes, duplicates, head and tail removal
		queue_op(OP_FIND, 32'h0000_0000, 4'd0);
		queue_op(OP_REMOVE, 32'h0, 4'd0);
		queue_op(OP_UNUSED, 32'h0, 4'd0);
		queue_op(OP_APPEND, 32'h0000_0000, 4'd15);
		queue_op(OP_APPEND, 32'hFFFF_FFFF, 4'd0);
		queue_op(OP_APPEND, 32'h8000_0001, 4'd0);
		queue_op(OP_FIND, 32'hFFFF_FFFF, 4'd15);
		queue_op(OP_FIND, 32'h0000_0000, 4'd0);
		queue_op(OP_FIND, 32'h1234_5678, 4'd0);
		queue_op(OP_REMOVE, 32'hFFFF_FFFF, 4'd15);
		queue_op(OP_REMOVE, 32'h0, 4'd3);
		queue_op(OP_APPEND, 32'hFFFF_FFFF, 4'd0);
		queue_op(OP_FIND, 32'hFFFF_FFFF, 4'd0);
		queue_op(OP_REMOVE, 32'h0, 4'd0);
		queue_op(OP_FIND, 32'hFFFF_FFFF, 4'd0);
		queue_op(OP_FIND, 32'h0000_0000, 4'd0);
		queue_op(OP_REMOVE, 32'h0, 4'd2);
		queue_op(OP_UNUSED, 32'hFFFF_FFFF, 4'd15);
		queue_op(OP_REMOVE, 32'h0, 4'd0);
		queue_op(OP_REMOVE, 32'h0, 4'd0);
		queue_op(OP_FIND, 32'h8000_0001, 4'd0);
		drain_all();

		// no idling; receiver held off long enough to back up the input
		queue_random(300);
		rsp_hold_len = 300;
		rsp_hold_go = ~rsp_hold_go;
		drain_all();

		send_idle_pct = 82;
		stall_pct = 0;
		queue_random(300);
		drain_all();

		send_idle_pct = 0;
		stall_pct = 82;
		queue_random(300);
		drain_all();

		send_idle_pct = 11;
		stall_pct = 11;
		queue_random(300);
		drain_all();

		repeat (10) @(negedge clk);
		if (errors == 0 && expected_rsp.size() == 0)
			$display("[ordered_list_append_find_remove_unit] OK");
		else
			$display("[ordered_list_append_find_remove_unit] ERROR");
		$finish;
	end

endmodule
